// File: src/tick_offset_slew_controller_unit_macros.svh
// ---------------------------------------------------------------------------
// tick offset slew controller assertion macros
// short forms for the clocked checks of the top level
// ---------------------------------------------------------------------------
`ifndef TICK_OFFSET_SLEW_CONTROLLER_UNIT_MACROS_SVH
`define TICK_OFFSET_SLEW_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TOSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TOSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tosc_pkg.sv
// ---------------------------------------------------------------------------
// tosc_pkg
// types, codes and constants shared by the slew controller modules
// ---------------------------------------------------------------------------
`default_nettype none

package tosc_pkg;

  // input beat: one observation
  typedef struct packed {
    logic [23:0] rtt_sample;
    logic [63:0] client_tick;
    logic [63:0] server_tick;
  } tosc_in_t;

  // output beat: slew factor and target lead
  typedef struct packed {
    logic [16:0] slew_factor;
    logic [31:0] target_offset;
  } tosc_out_t;

  // configuration register indexes
  localparam logic [2:0] CFG_TICK_RATE     = 3'd0;
  localparam logic [2:0] CFG_MARGIN_TICKS  = 3'd1;
  localparam logic [2:0] CFG_SLEW_GAIN     = 3'd2;
  localparam logic [2:0] CFG_MAX_SLEW      = 3'd3;
  localparam logic [2:0] CFG_FEEDBACK_TRIM = 3'd4;

  // sequencer state codes
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_JIT_MUL  = 4'd1;
  localparam logic [3:0] ST_JIT_UPD  = 4'd2;
  localparam logic [3:0] ST_RTT_MUL  = 4'd3;
  localparam logic [3:0] ST_RTT_UPD  = 4'd4;
  localparam logic [3:0] ST_TGT_MUL  = 4'd5;
  localparam logic [3:0] ST_TGT_ADD  = 4'd6;
  localparam logic [3:0] ST_ERR      = 4'd7;
  localparam logic [3:0] ST_SLEW_MUL = 4'd8;
  localparam logic [3:0] ST_SLEW     = 4'd9;

  // smoothing weight 0.1 in Q0.16
  localparam logic [15:0] EMA_WEIGHT = 16'd6554;

  // step strobes from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic jit_mul;
    logic jit_upd;
    logic rtt_mul;
    logic rtt_upd;
    logic tgt_mul;
    logic tgt_add;
    logic err_calc;
    logic slew_mul;
    logic slew_done;
  } tosc_ctrl_t;

endpackage

`default_nettype wire

// File: src/tosc_mul.sv
// ---------------------------------------------------------------------------
// tosc_mul
// shared unsigned 32x16 multiplier with registered product
// ---------------------------------------------------------------------------
`default_nettype none

module tosc_mul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [15:0] b_i,
  output logic      [47:0] p_o
);

  logic [47:0] prod_q;
  logic [47:0] prod_d;

  assign prod_d = 48'(a_i) * 48'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign p_o = prod_q;

endmodule

`default_nettype wire

// File: src/tosc_seq.sv
// ---------------------------------------------------------------------------
// tosc_seq
// step sequencer for one observation through the shared multiplier
// ---------------------------------------------------------------------------
`default_nettype none

module tosc_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                seeded_i,
  input  wire logic                out_free_i,
  output logic                     busy_o,
  output tosc_pkg::tosc_ctrl_t     ctrl_o
);

  import tosc_pkg::*;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_JIT_MUL;
        end
      end
      // first observation only seeds, straight on to the target
      ST_JIT_MUL:  state_d = seeded_i ? ST_JIT_UPD : ST_TGT_MUL;
      ST_JIT_UPD:  state_d = ST_RTT_MUL;
      ST_RTT_MUL:  state_d = ST_RTT_UPD;
      ST_RTT_UPD:  state_d = ST_TGT_MUL;
      ST_TGT_MUL:  state_d = ST_TGT_ADD;
      ST_TGT_ADD:  state_d = ST_ERR;
      ST_ERR:      state_d = ST_SLEW_MUL;
      ST_SLEW_MUL: state_d = ST_SLEW;
      ST_SLEW: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.jit_mul   = (state_q == ST_JIT_MUL);
    ctrl_o.jit_upd   = (state_q == ST_JIT_UPD);
    ctrl_o.rtt_mul   = (state_q == ST_RTT_MUL);
    ctrl_o.rtt_upd   = (state_q == ST_RTT_UPD);
    ctrl_o.tgt_mul   = (state_q == ST_TGT_MUL);
    ctrl_o.tgt_add   = (state_q == ST_TGT_ADD);
    ctrl_o.err_calc  = (state_q == ST_ERR);
    ctrl_o.slew_mul  = (state_q == ST_SLEW_MUL);
    ctrl_o.slew_done = (state_q == ST_SLEW) && out_free_i;
  end

endmodule

`default_nettype wire

// File: src/tick_offset_slew_controller_unit.sv
// ---------------------------------------------------------------------------
// tick offset slew controller
// smooths rtt and jitter, forms a target tick lead and a clamped slew factor
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ----------------------------------
//  in       in   in_valid_i/in_stall_o  tosc_in_t  rtt, client/server tick
//  out      out  out_valid_o/out_stall_i tosc_out_t slew factor, target
//  cfg      in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
//  an observation runs from the beat through the jitter, rtt, target, error
//  and slew steps (the first, which only seeds, skips the jitter and rtt
//  updates); a seeded one makes four passes through the one shared 32x16
//  multiplier, each a multiply step, then a use of the registered product
//  in_stall_o is high while the sequencer works; a finished result sits in
//  the output register, so a stalled output only holds the last step
//  reset clears the estimates, the seeded flag and loads the register defaults
// ---------------------------------------------------------------------------
`default_nettype none

module tick_offset_slew_controller_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // observation channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tosc_pkg::tosc_in_t   in_data_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tosc_pkg::tosc_out_t       out_data_o,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [15:0]          cfg_wdata_i
);

  import tosc_pkg::*;

  // rounding shift by 16 of a product magnitude, ties away from zero
  function automatic logic [32:0] rnd16(input logic [47:0] p);
    logic [48:0] s;
    begin
      s = 49'(p) + 49'd32768;
      return s[48:16];
    end
  endfunction

  // apply a signed rounded step to a 24-bit estimate, clamped to its range
  function automatic logic [23:0] ema_apply(input logic [23:0] old, input logic neg,
                                            input logic [32:0] r);
    logic signed [34:0] v;
    begin
      if (neg) begin
        v = $signed({11'b0, old}) - $signed({2'b0, r});
      end else begin
        v = $signed({11'b0, old}) + $signed({2'b0, r});
      end
      if (v < 0) begin
        return '0;
      end else if (v > 35'sd16777215) begin
        return 24'hFFFFFF;
      end else begin
        return v[23:0];
      end
    end
  endfunction

  // configuration registers
  logic [10:0] tick_rate_q;
  logic [15:0] margin_q;
  logic [15:0] gain_q;
  logic [15:0] max_slew_q;
  logic [15:0] trim_q;

  // estimator state
  logic [23:0] srtt_q;
  logic [23:0] sjit_q;
  logic        seeded_q;

  // captured observation and intermediates
  logic [23:0]        rtt_q;
  logic [63:0]        cli_q;
  logic [63:0]        srv_q;
  logic [63:0]        diff_q;
  logic signed [34:0] off_q;
  logic [31:0]        tgt_q;
  logic               neg_q;
  logic [31:0]        err_mag_q;

  // output register
  logic      out_valid_q;
  tosc_out_t out_data_q;

  tosc_ctrl_t  ctrl;
  logic        busy;
  logic        out_free;

  // shared multiplier
  logic        mul_en;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;

  // combinational helpers
  logic        rtt_neg;
  logic [23:0] rtt_mag;
  logic        jit_neg;
  logic [23:0] jit_mag;
  logic [24:0] est_sum;
  logic [32:0] prod_rnd;

  logic signed [34:0] off_d;
  logic signed [39:0] tgt_sum;
  logic [31:0]        tgt_d;
  logic signed [52:0] err_s;
  logic [52:0]        err_abs;
  logic [31:0]        err_mag_d;
  logic signed [34:0] slew_s;
  logic signed [34:0] slew_lo;
  logic signed [34:0] slew_hi;
  logic [16:0]        slew_d;

  assign out_free = !out_valid_q || !out_stall_i;

  tosc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .seeded_i   (seeded_q),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  assign in_stall_o = busy;

  // sample versus smoothed rtt; its magnitude is also the jitter sample
  assign rtt_neg = rtt_q < srtt_q;
  assign rtt_mag = rtt_neg ? (srtt_q - rtt_q) : (rtt_q - srtt_q);
  assign jit_neg = rtt_mag < sjit_q;
  assign jit_mag = jit_neg ? (sjit_q - rtt_mag) : (rtt_mag - sjit_q);
  assign est_sum = {1'b0, srtt_q} + {1'b0, sjit_q};

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    if (ctrl.jit_mul) begin
      mul_en = 1'b1;
      mul_a  = {8'b0, jit_mag};
      mul_b  = EMA_WEIGHT;
    end else if (ctrl.rtt_mul) begin
      mul_en = 1'b1;
      mul_a  = {8'b0, rtt_mag};
      mul_b  = EMA_WEIGHT;
    end else if (ctrl.tgt_mul) begin
      mul_en = 1'b1;
      mul_a  = {7'b0, est_sum};
      mul_b  = {5'b0, tick_rate_q};
    end else if (ctrl.slew_mul) begin
      mul_en = 1'b1;
      mul_a  = err_mag_q;
      mul_b  = gain_q;
    end
  end

  tosc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_rnd = rnd16(prod);

  // tick difference read as signed, clamped to +-2^33
  always_comb begin
    if ($signed(diff_q) > 64'sd8589934592) begin
      off_d = 35'sd8589934592;
    end else if ($signed(diff_q) < -64'sd8589934592) begin
      off_d = -35'sd8589934592;
    end else begin
      off_d = $signed(diff_q[34:0]);
    end
  end

  // target lead: product plus margin minus trim, floored and saturated
  assign tgt_sum = $signed({3'b0, prod[36:0]}) + $signed({16'b0, margin_q, 8'b0})
                 - $signed({{16{trim_q[15]}}, trim_q, 8'b0});

  always_comb begin
    if (tgt_sum < 0) begin
      tgt_d = '0;
    end else if (tgt_sum > 40'sh00FFFFFFFF) begin
      tgt_d = 32'hFFFFFFFF;
    end else begin
      tgt_d = tgt_sum[31:0];
    end
  end

  // offset error; magnitudes past 32 bits drive any nonzero gain to the clamp,
  // so saturating there gives the same slew as the wider limit
  assign err_s   = $signed({21'b0, tgt_q}) - $signed({{2{off_q[34]}}, off_q, 16'b0});
  assign err_abs = err_s[52] ? 53'(-err_s) : 53'(err_s);
  assign err_mag_d = (|err_abs[52:32]) ? 32'hFFFFFFFF : err_abs[31:0];

  // slew factor around one, clamped to one plus or minus max slew
  assign slew_lo = 35'sd65536 - $signed({19'b0, max_slew_q});
  assign slew_hi = 35'sd65536 + $signed({19'b0, max_slew_q});

  always_comb begin
    if (neg_q) begin
      slew_s = 35'sd65536 - $signed({2'b0, prod_rnd});
    end else begin
      slew_s = 35'sd65536 + $signed({2'b0, prod_rnd});
    end
    if (slew_s < slew_lo) begin
      slew_d = slew_lo[16:0];
    end else if (slew_s > slew_hi) begin
      slew_d = slew_hi[16:0];
    end else begin
      slew_d = slew_s[16:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= 11'd60;
      margin_q    <= 16'd512;
      gain_q      <= 16'd3277;
      max_slew_q  <= 16'd3277;
      trim_q      <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_RATE:     tick_rate_q <= cfg_wdata_i[10:0];
        CFG_MARGIN_TICKS:  margin_q    <= cfg_wdata_i;
        CFG_SLEW_GAIN:     gain_q      <= cfg_wdata_i;
        CFG_MAX_SLEW:      max_slew_q  <= cfg_wdata_i;
        CFG_FEEDBACK_TRIM: trim_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt_q   <= '0;
      sjit_q   <= '0;
      seeded_q <= 1'b0;
    end else begin
      if (ctrl.jit_mul && !seeded_q) begin
        // first observation seeds rtt, jitter starts at zero
        srtt_q   <= rtt_q;
        sjit_q   <= '0;
        seeded_q <= 1'b1;
      end
      if (ctrl.jit_upd) begin
        sjit_q <= ema_apply(sjit_q, neg_q, prod_rnd);
      end
      if (ctrl.rtt_upd) begin
        srtt_q <= ema_apply(srtt_q, neg_q, prod_rnd);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      rtt_q <= in_data_i.rtt_sample;
      cli_q <= in_data_i.client_tick;
      srv_q <= in_data_i.server_tick;
    end
    if (ctrl.jit_mul) begin
      diff_q <= cli_q - srv_q;
      neg_q  <= jit_neg;
    end
    if (ctrl.rtt_mul) begin
      neg_q <= rtt_neg;
    end
    if (ctrl.tgt_mul) begin
      off_q <= off_d;
    end
    if (ctrl.tgt_add) begin
      tgt_q <= tgt_d;
    end
    if (ctrl.err_calc) begin
      err_mag_q <= err_mag_d;
      neg_q     <= err_s[52];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.slew_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.slew_done) begin
      out_data_q.slew_factor   <= slew_d;
      out_data_q.target_offset <= tgt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `include "tick_offset_slew_controller_unit_macros.svh"

  // an accepted beat starts the sequencer at once
  `TOSC_ASSERT_NXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o, "not busy after beat")
  // estimates only move while an observation is in work
  `TOSC_ASSERT_NXT(a_est_hold_idle, !in_stall_o, $stable(srtt_q) && $stable(sjit_q), "estimate moved while idle")
  // no result can exist before the estimator was seeded
  `TOSC_ASSERT_IMP(a_out_after_seed, out_valid_o, seeded_q, "result before seed")

endmodule

`default_nettype wire
